>>> sv/contiguous_cell_allocator_macros.svh
// ---------------------------------------------------------------------------
// Contiguous cell allocator assertion macros
// Shorthand for the concurrent checks at the end of the top level. They use
// clk and rst_n from the scope that expands them.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_CELL_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_CELL_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define CCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/cca_pkg.sv
// ---------------------------------------------------------------------------
// Contiguous cell allocator package
// Field widths, codes, controller states and the command/status bundles
// shared between the controller and the datapath.
// ---------------------------------------------------------------------------
package cca_pkg;

  // Fixed field widths
  localparam int KIND_W   = 1;
  localparam int OWNER_W  = 16;
  localparam int SIZE_W   = 11;
  localparam int STATUS_W = 2;
  localparam int START_W  = 10;
  localparam int POL_W    = 2;

  // Defaults for the top-level parameters
  localparam int CELLS_DEF      = 1024;
  localparam int OWNER_BITS_DEF = 16;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] RES_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] RES_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] RES_INVALID = 2'd2;

  // Fit policies; the spare code behaves as first fit
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_PURGE,
    ST_FILL,
    ST_DONE
  } cca_state_t;

  // Controller to datapath
  typedef struct packed {
    logic                load;
    logic                init_en;
    logic                scan_en;
    logic                fill_load;
    logic                fill_en;
    logic                res_load;
    logic [STATUS_W-1:0] res_code;
  } cca_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic init_last;
    logic req_bad;
    logic req_big;
    logic req_clear;
    logic scan_done;
    logic found;
    logic fill_last;
    logic out_free;
  } cca_sts_t;

endpackage

>>> sv/cca_req_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or clear request.
// ---------------------------------------------------------------------------
interface cca_req_if;
  import cca_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [OWNER_W-1:0] owner;
  logic [SIZE_W-1:0]  size;

  modport source (output valid, kind, owner, size, input ready);
  modport sink   (input valid, kind, owner, size, output ready);
endinterface

>>> sv/cca_rsp_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result per request.
// ---------------------------------------------------------------------------
interface cca_rsp_if;
  import cca_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  start_cell;

  modport source (output valid, status, start_cell, input ready);
  modport sink   (input valid, status, start_cell, output ready);
endinterface

>>> sv/cca_datapath.sv
// ---------------------------------------------------------------------------
// Allocator datapath
// Owner tag memory with one write and one registered read port, the scan
// address generator, free-run tracker, fill counter, fit policy register and
// the result register.
// ---------------------------------------------------------------------------
module cca_datapath #(
  parameter int CELLS      = cca_pkg::CELLS_DEF,
  parameter int OWNER_BITS = cca_pkg::OWNER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cca_pkg::cca_cmd_t             cmd,
  output cca_pkg::cca_sts_t             sts,
  input  logic [cca_pkg::KIND_W-1:0]    in_kind,
  input  logic [cca_pkg::OWNER_W-1:0]   in_owner,
  input  logic [cca_pkg::SIZE_W-1:0]    in_size,
  input  logic                          cfg_we,
  input  logic [cca_pkg::POL_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cca_pkg::STATUS_W-1:0]  out_status,
  output logic [cca_pkg::START_W-1:0]   out_start_cell
);
  import cca_pkg::*;

  localparam int AW = $clog2(CELLS);
  localparam int LW = $clog2(CELLS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

  // Tag memory
  logic [OWNER_BITS-1:0] mem [CELLS];
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [OWNER_BITS-1:0] mem_wd;

  // Request registers
  logic [OWNER_BITS-1:0] owner_r;
  logic [KIND_W-1:0]     kind_r;
  logic [LW-1:0]         need_r;
  logic [POL_W-1:0]      policy_r;

  // Scan pipeline
  logic [AW-1:0]         init_cnt_r;
  logic [AW-1:0]         rd_addr_r;
  logic                  issue_done_r;
  logic                  rd_vld_r;
  logic [AW-1:0]         rd_idx_r;
  logic [OWNER_BITS-1:0] rd_data_r;
  logic                  issue;

  // Run tracker
  logic                  in_run_r;
  logic [LW-1:0]         run_len_r;
  logic [AW-1:0]         run_start_r;
  logic                  found_r;
  logic [LW-1:0]         best_len_r;
  logic [AW-1:0]         best_start_r;

  // Fill
  logic [AW-1:0]         fill_addr_r;
  logic [LW-1:0]         fill_cnt_r;

  // Result register
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [START_W-1:0]    out_start_r;

  logic [OWNER_BITS-1:0] owner_eff;
  logic                  cell_free;
  logic                  cell_last;
  logic [LW-1:0]         cur_len;
  logic [AW-1:0]         cur_start;
  logic                  run_end;
  logic                  take;
  logic                  track;
  logic                  purge_hit;

  // Request decode straight from the input payload, and status back to the
  // controller
  always_comb begin
    owner_eff     = OWNER_BITS'(in_owner);
    sts.req_bad   = (owner_eff == '0) || ((in_kind == KIND_ALLOC) && (in_size == '0));
    sts.req_big   = 32'(in_size) > 32'(CELLS);
    sts.req_clear = (in_kind == KIND_CLEAR);
    sts.init_last = (init_cnt_r == LAST_ADDR);
    sts.scan_done = issue_done_r && !rd_vld_r;
    sts.found     = found_r;
    sts.fill_last = (fill_cnt_r == LW'(1));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Run evaluation on the cell whose tag has just come back
  always_comb begin
    issue     = cmd.scan_en && !issue_done_r;
    cell_free = (rd_data_r == '0);
    cell_last = (rd_idx_r == LAST_ADDR);
    cur_len   = in_run_r ? (run_len_r + LW'(cell_free)) : LW'(cell_free);
    cur_start = in_run_r ? run_start_r : rd_idx_r;
    run_end   = in_run_r ? (!cell_free || cell_last) : (cell_free && cell_last);
    take      = (cur_len >= need_r) &&
                (!found_r ||
                 ((policy_r == POL_BEST) && (cur_len < best_len_r)) ||
                 ((policy_r == POL_WORST) && (cur_len > best_len_r)));
    track     = rd_vld_r && (kind_r == KIND_ALLOC);
    purge_hit = rd_vld_r && (kind_r == KIND_CLEAR) && (rd_data_r == owner_r);
  end

  // Memory write port select
  always_comb begin
    mem_we = 1'b0;
    mem_wa = fill_addr_r;
    mem_wd = owner_r;
    if (cmd.init_en) begin
      mem_we = 1'b1;
      mem_wa = init_cnt_r;
      mem_wd = '0;
    end else if (cmd.fill_en) begin
      mem_we = 1'b1;
    end else if (purge_hit) begin
      mem_we = 1'b1;
      mem_wa = rd_idx_r;
      mem_wd = '0;
    end
  end

  // Tag memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  // Fit policy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIRST;
    end else if (cfg_we) begin
      policy_r <= cfg_wdata;
    end
  end

  // Reset sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r <= '0;
    end else if (cmd.init_en) begin
      init_cnt_r <= init_cnt_r + AW'(1);
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      owner_r <= owner_eff;
      kind_r  <= in_kind;
      need_r  <= LW'(in_size);
    end
  end

  // Read address generator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r    <= '0;
      issue_done_r <= 1'b0;
      rd_vld_r     <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (cmd.load) begin
        rd_addr_r    <= '0;
        issue_done_r <= 1'b0;
      end else if (issue) begin
        rd_addr_r <= rd_addr_r + AW'(1);
        if (rd_addr_r == LAST_ADDR) begin
          issue_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_addr_r;
  end

  // Free-run tracking and best candidate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r <= 1'b0;
      found_r  <= 1'b0;
    end else if (cmd.load) begin
      in_run_r <= 1'b0;
      found_r  <= 1'b0;
    end else if (track) begin
      in_run_r <= cell_free;
      if (run_end && take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (track) begin
      run_len_r   <= cur_len;
      run_start_r <= cur_start;
      if (run_end && take) begin
        best_len_r   <= cur_len;
        best_start_r <= cur_start;
      end
    end
  end

  // Fill address and count
  always_ff @(posedge clk) begin
    if (cmd.fill_load) begin
      fill_addr_r <= best_start_r;
      fill_cnt_r  <= need_r;
    end else if (cmd.fill_en) begin
      fill_addr_r <= fill_addr_r + AW'(1);
      fill_cnt_r  <= fill_cnt_r - LW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= cmd.res_code;
      out_start_r  <= ((cmd.res_code == RES_OK) && (kind_r == KIND_ALLOC)) ?
                      START_W'(best_start_r) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_start_cell = out_start_r;

endmodule

>>> sv/cca_ctrl.sv
// ---------------------------------------------------------------------------
// Allocator controller
// Sequences the reset sweep, the scan, the tag fill, the owner purge and the
// hand-over of the result to the result register.
// ---------------------------------------------------------------------------
module cca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cca_pkg::cca_sts_t sts,
  output cca_pkg::cca_cmd_t cmd
);
  import cca_pkg::*;

  cca_state_t          state_r, state_nxt;
  logic [STATUS_W-1:0] res_code_r, res_code_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      res_code_r <= RES_OK;
    end else begin
      state_r    <= state_nxt;
      res_code_r <= res_code_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    res_code_nxt  = res_code_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.res_code  = res_code_r;
    unique case (state_r)
      ST_INIT: begin
        cmd.init_en = 1'b1;
        if (sts.init_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.req_bad) begin
            res_code_nxt = RES_INVALID;
            state_nxt    = ST_DONE;
          end else if (sts.req_clear) begin
            state_nxt = ST_PURGE;
          end else if (sts.req_big) begin
            res_code_nxt = RES_NOSPACE;
            state_nxt    = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.fill_load = 1'b1;
            state_nxt     = ST_FILL;
          end else begin
            res_code_nxt = RES_NOSPACE;
            state_nxt    = ST_DONE;
          end
        end
      end
      ST_PURGE: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          res_code_nxt = RES_OK;
          state_nxt    = ST_DONE;
        end
      end
      ST_FILL: begin
        cmd.fill_en = 1'b1;
        if (sts.fill_last) begin
          res_code_nxt = RES_OK;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/contiguous_cell_allocator.sv
// ---------------------------------------------------------------------------
// Contiguous cell allocator
// Owner-tagged cell store with first, best and worst fit allocation of
// contiguous runs and per-owner release.
// ---------------------------------------------------------------------------
//  Channel  | Dir | Handshake           | Payload
//  ---------+-----+---------------------+----------------------------
//  in_req   | in  | valid/ready         | kind, owner, size
//  out_rsp  | out | valid/ready         | status, start_cell
//  cfg      | in  | cfg_we, no wait     | cfg_wdata = fit policy
//
// Allocate: scan the tags, tag the run, then hand over; clear: scan the tags
// and zero the owner's cells, then hand over; rejected requests: hand over only.
// The single tag memory read port, one cell per cycle, sets the scan length.
// After reset a sweep zeroes the tags; no request is taken then.
// A result register lets the next request enter while a result is stalled.
// ---------------------------------------------------------------------------
`include "contiguous_cell_allocator_macros.svh"

module contiguous_cell_allocator #(
  parameter int CELLS      = cca_pkg::CELLS_DEF,
  parameter int OWNER_BITS = cca_pkg::OWNER_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  cca_req_if.sink                   in_req,
  cca_rsp_if.source                 out_rsp,
  input  logic                      cfg_we,
  input  logic [cca_pkg::POL_W-1:0] cfg_wdata
);
  import cca_pkg::*;

  cca_cmd_t   cmd;
  cca_sts_t   sts;
  logic       in_ready;
  logic [2:0] mem_ops;

  cca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cca_datapath #(
    .CELLS      (CELLS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_req.kind),
    .in_owner       (in_req.owner),
    .in_size        (in_req.size),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_rsp.valid),
    .out_ready      (out_rsp.ready),
    .out_status     (out_rsp.status),
    .out_start_cell (out_rsp.start_cell)
  );

  assign in_req.ready = in_ready;

  // Memory activities the controller may request
  assign mem_ops = {cmd.init_en, cmd.fill_en, cmd.scan_en};

  // Checks
  `CCA_ASSERT_NEXT(a_busy_after_accept, in_req.valid && in_req.ready, !in_req.ready, "request taken while busy")
  `CCA_ASSERT_NOW(a_one_mem_op, 1'b1, $onehot0(mem_ops), "overlapping memory operations")
  `CCA_ASSERT_NOW(a_no_start_on_fail, out_rsp.valid && (out_rsp.status != RES_OK), out_rsp.start_cell == '0, "start cell on failed result")
  `CCA_ASSERT_NEXT(a_fill_after_scan, cmd.fill_load, cmd.fill_en, "fill did not follow the scan")

endmodule

>>> verif/contiguous_cell_allocator_checker.sv
// ---------------------------------------------------------------------------
// Contiguous cell allocator checker
// Watches the request, result and policy ports. It keeps its own copy of
// the owner tags and the fit policy, works out the result of every accepted
// request, and compares each accepted result with the oldest one due.
// ---------------------------------------------------------------------------
module contiguous_cell_allocator_checker #(
  parameter int CELLS      = cca_pkg::CELLS_DEF,
  parameter int OWNER_BITS = cca_pkg::OWNER_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  cca_req_if                        req_mon,
  cca_rsp_if                        rsp_mon,
  input  logic                      cfg_we,
  input  logic [cca_pkg::POL_W-1:0] cfg_wdata,
  output int                        fails,
  output int                        pending
);
  import cca_pkg::*;

  // Owner bits above OWNER_BITS are dropped before use
  localparam logic [OWNER_W-1:0] TAG_MASK = (OWNER_BITS >= OWNER_W) ? {OWNER_W{1'b1}} :
                                            OWNER_W'((64'd1 << OWNER_BITS) - 64'd1);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  start_cell;
  } alloc_result_t;

  logic [OWNER_W-1:0] tag_store [CELLS];
  logic [POL_W-1:0]   fit_mode;
  alloc_result_t      due_results [$];
  alloc_result_t      due;
  int                 mismatches;

  initial begin
    fails   = 0;
    pending = 0;
  end

  // Walk the maximal free runs and pick one that holds need cells
  function automatic bit locate_hole(input int need, input logic [POL_W-1:0] pol,
                                     output int hole_at);
    int pos;
    int run_lo;
    int run_len;
    int pick_len;
    bit hit;
    hit      = 1'b0;
    hole_at  = 0;
    pick_len = 0;
    pos      = 0;
    while (pos < CELLS) begin
      if (tag_store[pos] != '0) begin
        pos++;
      end else begin
        run_lo = pos;
        while (pos < CELLS && tag_store[pos] == '0) pos++;
        run_len = pos - run_lo;
        if (run_len >= need) begin
          if (!hit) begin
            hit      = 1'b1;
            hole_at  = run_lo;
            pick_len = run_len;
            // first fit, and the spare code, stop at the lowest run
            if (pol != POL_BEST && pol != POL_WORST) break;
          end else if (pol == POL_BEST && run_len < pick_len) begin
            hole_at  = run_lo;
            pick_len = run_len;
          end else if (pol == POL_WORST && run_len > pick_len) begin
            hole_at  = run_lo;
            pick_len = run_len;
          end
        end
      end
    end
    return hit;
  endfunction

  // Apply one request to the tag copy and return its result
  function automatic alloc_result_t serve_request(input logic [KIND_W-1:0]  kind,
                                                  input logic [OWNER_W-1:0] owner,
                                                  input logic [SIZE_W-1:0]  size);
    alloc_result_t      res;
    logic [OWNER_W-1:0] tag;
    int                 need;
    int                 hole_at;
    res.status     = RES_OK;
    res.start_cell = '0;
    tag            = owner & TAG_MASK;
    need           = int'(size);
    if (tag == '0) begin
      res.status = RES_INVALID;
    end else if (kind == KIND_CLEAR) begin
      foreach (tag_store[i])
        if (tag_store[i] == tag) tag_store[i] = '0;
    end else if (need == 0) begin
      res.status = RES_INVALID;
    end else if (need > CELLS || !locate_hole(need, fit_mode, hole_at)) begin
      res.status = RES_NOSPACE;
    end else begin
      for (int i = 0; i < need; i++) tag_store[hole_at + i] = tag;
      res.start_cell = hole_at[START_W-1:0];
    end
    return res;
  endfunction

  // Inputs are driven off the clock edge, so values read here are pre-edge
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (tag_store[i]) tag_store[i] = '0;
      fit_mode   = POL_FIRST;
      mismatches = 0;
      due_results.delete();
    end else begin
      // results leaving the block
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: status %0d start_cell %0d",
                 rsp_mon.status, rsp_mon.start_cell);
          mismatches++;
        end else begin
          due = due_results.pop_front();
          if (rsp_mon.status !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, rsp_mon.status);
            mismatches++;
          end
          if (rsp_mon.start_cell !== due.start_cell) begin
            $error("start_cell: expected %0d, actual %0d", due.start_cell,
                   rsp_mon.start_cell);
            mismatches++;
          end
        end
      end
      // policy writes are to be made only while the block is idle; the block does not enforce this
      if (cfg_we) fit_mode = cfg_wdata;
      // requests entering the block
      if (req_mon.valid && req_mon.ready)
        due_results.push_back(serve_request(req_mon.kind, req_mon.owner, req_mon.size));
    end
    pending <= due_results.size();
    fails   <= mismatches;
  end

endmodule

>>> verif/contiguous_cell_allocator_test.sv
// ---------------------------------------------------------------------------
// Contiguous cell allocator testbench
// Drives allocate and clear requests in bursts under each fit policy, with
// a stalling result receiver and one long hold-off, and leaves prediction
// and comparison to the checker beside the block.
// ---------------------------------------------------------------------------
module contiguous_cell_allocator_test;
  import cca_pkg::*;

  localparam int               CELLS     = CELLS_DEF;
  localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [POL_W-1:0] cfg_wdata;
  int               fails;
  int               pending;

  // Sender state
  int                 burst_left;
  logic [OWNER_W-1:0] owner_pool [8];

  cca_req_if req_ch ();
  cca_rsp_if rsp_ch ();

  contiguous_cell_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  contiguous_cell_allocator_checker #(
    .CELLS      (CELLS),
    .OWNER_BITS (OWNER_BITS_DEF)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_mon   (req_ch),
    .rsp_mon   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, well beyond the slowest passing run
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one request, with a random gap first when a burst has run out
  task automatic push_request(input logic [KIND_W-1:0]  k,
                              input logic [OWNER_W-1:0] o,
                              input logic [SIZE_W-1:0]  s);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 1500) : $urandom_range(1, 20);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= k;
    req_ch.owner <= o;
    req_ch.size  <= s;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // Drain every outstanding result, then write the fit policy
  task automatic set_policy(input logic [POL_W-1:0] pol);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= pol;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A phase of random requests under one policy
  task automatic random_phase(input logic [POL_W-1:0] pol, input int count);
    int                 pick;
    int                 sel;
    logic [KIND_W-1:0]  k;
    logic [OWNER_W-1:0] o;
    logic [SIZE_W-1:0]  s;
    set_policy(pol);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 99);
      k    = KIND_ALLOC;
      o    = owner_pool[$urandom_range(0, 7)];
      s    = SIZE_W'($urandom_range(1, 48));
      if (pick < 55) begin
        // well-formed allocate, mostly small runs
        if (sel < 8) s = SIZE_W'($urandom_range(49, 400));
        else if (sel < 11) s = SIZE_W'($urandom_range(401, CELLS));
      end else if (pick < 80) begin
        k = KIND_CLEAR;
        s = SIZE_W'($urandom_range(0, 2047));
      end else if (pick < 86) begin
        // owner zero, either kind
        k = $urandom_range(0, 1) ? KIND_CLEAR : KIND_ALLOC;
        o = '0;
        s = SIZE_W'($urandom_range(0, 2047));
      end else if (pick < 90) begin
        s = '0;
      end else if (pick < 94) begin
        s = SIZE_W'($urandom_range(CELLS + 1, 2047));
      end else begin
        // stray owner, anywhere in the tag space
        k = $urandom_range(0, 1) ? KIND_CLEAR : KIND_ALLOC;
        o = OWNER_W'($urandom_range(0, 16'hFFFF));
        s = SIZE_W'($urandom_range(0, 64));
      end
      push_request(k, o, s);
    end
  endtask

  // Result receiver: changing stall patterns and one long hold-off
  initial begin : receiver
    int          taken;
    int          tick;
    int          stall_mode;
    bit          held_off;
    logic [31:0] stall_bits;
    taken      = 0;
    tick       = 0;
    stall_mode = 0;
    held_off   = 1'b0;
    stall_bits = '1;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) taken++;
      if (!held_off && taken >= 60) begin
        // the block fills up behind this and stops taking requests
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (8000) @(posedge clk);
      end
      if (tick % 48 == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_bits = $urandom;
      end
      tick++;
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= stall_bits[tick % 32];
        2: rsp_ch.ready <= stall_bits[tick % 32] & stall_bits[(tick + 7) % 32];
        default: rsp_ch.ready <= stall_bits[tick % 32] | stall_bits[(tick + 3) % 32];
      endcase
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= POL_FIRST;
    req_ch.valid <= 1'b0;
    req_ch.kind  <= KIND_ALLOC;
    req_ch.owner <= '0;
    req_ch.size  <= '0;
    burst_left   = 0;
    owner_pool[0] = 16'hFFFF;
    owner_pool[1] = 16'h0001;
    for (int i = 2; i < 8; i++) owner_pool[i] = OWNER_W'($urandom_range(1, 16'hFFFF));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Rejections, oversize requests and a full store, at the reset policy
    push_request(KIND_ALLOC, 16'h0000, 11'd5);
    push_request(KIND_ALLOC, 16'h0001, 11'd0);
    push_request(KIND_CLEAR, 16'h0000, 11'd0);
    push_request(KIND_CLEAR, 16'h1234, 11'd7);
    push_request(KIND_ALLOC, 16'hFFFF, 11'd2047);
    push_request(KIND_ALLOC, 16'hFFFF, 11'd1025);
    push_request(KIND_ALLOC, 16'hFFFF, 11'd1024);
    push_request(KIND_ALLOC, 16'h0002, 11'd1);
    push_request(KIND_CLEAR, 16'hFFFF, 11'd0);
    // Carve holes of 100, 300, 50 and 544 cells
    push_request(KIND_ALLOC, 16'h0001, 11'd100);
    push_request(KIND_ALLOC, 16'h0002, 11'd10);
    push_request(KIND_ALLOC, 16'h0003, 11'd300);
    push_request(KIND_ALLOC, 16'h0004, 11'd10);
    push_request(KIND_ALLOC, 16'h0005, 11'd50);
    push_request(KIND_ALLOC, 16'h0006, 11'd10);
    push_request(KIND_CLEAR, 16'h0001, 11'd0);
    push_request(KIND_CLEAR, 16'h0003, 11'd0);
    push_request(KIND_CLEAR, 16'h0005, 11'd0);
    push_request(KIND_ALLOC, 16'h0007, 11'd40);
    // Best fit takes the exact hole, then the tightest one
    set_policy(POL_BEST);
    push_request(KIND_ALLOC, 16'h0008, 11'd50);
    push_request(KIND_ALLOC, 16'h0009, 11'd55);
    // Worst fit takes the largest hole, including an exact fit
    set_policy(POL_WORST);
    push_request(KIND_ALLOC, 16'h000A, 11'd300);
    push_request(KIND_ALLOC, 16'h000B, 11'd300);
    // Spare policy code falls back to first fit
    set_policy(POL_SPARE);
    push_request(KIND_ALLOC, 16'h000C, 11'd3);
    push_request(KIND_ALLOC, 16'h000D, 11'd1);

    random_phase(POL_BEST, 45);
    random_phase(POL_WORST, 45);
    random_phase(POL_FIRST, 45);
    random_phase(POL_SPARE, 45);
    random_phase(POL_WORST, 45);
    random_phase(POL_BEST, 45);

    // Let every result come home, then watch for strays
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * CELLS + 16) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/cca_pkg.sv
sv/cca_req_if.sv
sv/cca_rsp_if.sv
sv/cca_datapath.sv
sv/cca_ctrl.sv
sv/contiguous_cell_allocator.sv
verif/contiguous_cell_allocator_checker.sv
verif/contiguous_cell_allocator_test.sv
